// ===== src/greedy_move_merge_selector_top_macros.svh =====
// Assertion macros shared by the greedy move merge selector RTL.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef GREEDY_MOVE_MERGE_SELECTOR_TOP_MACROS_SVH
`define GREEDY_MOVE_MERGE_SELECTOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GMMS_ASSERT_NOW(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("gmms assertion failed");
`define GMMS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gmms assertion failed");
`else
`define GMMS_ASSERT_NOW(lbl, expr)
`define GMMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/gmms_pkg.sv =====
// Shared types, constants and the move overlap check of the selector.
// No dependencies.
`timescale 1ns / 1ps
package gmms_pkg;
   localparam int MAX_MOVES_DEF = 64;
   localparam int RESULT_CAP    = 64;
   localparam int PICK_IDX_W    = 6;
   localparam int PICK_CNT_W    = 7;
   localparam int MERGE_W       = 7;
   localparam int POS_W         = 10;
   localparam int COST_W        = 32;
   localparam int KIND_W        = 3;
   localparam int SPOS_W        = 13;

   localparam logic [KIND_W-1:0] KIND_SWAP    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TWO_OPT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_OR_1    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OR_2    = 3'd3;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [POS_W-1:0]         pos_first;
      logic [POS_W-1:0]         pos_second;
      logic signed [COST_W-1:0] cost;
   } move_entry_type;

   typedef enum logic [4:0] {
      OP_IDLE, OP_LOAD, OP_RD_I, OP_LAT_I, OP_RD_J, OP_CMP_J, OP_WR_I,
      OP_SEL_START, OP_RD_ORD, OP_LONE_WR, OP_RD_CAND, OP_LAT_CAND,
      OP_RD_PICK, OP_RD_PMV, OP_CHK, OP_ACCEPT, OP_NEXT_C,
      OP_OUT_START, OP_RD_OPK, OP_RD_OMV, OP_EMIT
   } op_type;

   typedef enum logic [4:0] {
      ST_LOAD, ST_RD_I, ST_LAT_I, ST_RD_J, ST_CMP_J, ST_WR_I,
      ST_SEL_START, ST_LONE_ORD, ST_LONE_WR, ST_RD_ORD, ST_RD_CAND,
      ST_LAT_CAND, ST_RD_PICK, ST_RD_PMV, ST_CHK, ST_ACCEPT, ST_NEXT_C,
      ST_OUT_START, ST_RD_OPK, ST_RD_OMV, ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_last;
      logic j_last;
      logic i_last;
      logic gain_lt2;
      logic npick_zero;
      logic compat_ok;
      logic k_last;
      logic stop;
      logic c_last;
      logic out_free;
      logic out_last;
   } status_type;

   function automatic logic signed [SPOS_W-1:0] spos(input logic [POS_W-1:0] p);
      spos = $signed({{(SPOS_W-POS_W){1'b0}}, p});
   endfunction

   function automatic logic signed [SPOS_W-1:0] seg_len(input logic [KIND_W-1:0] k);
      logic signed [SPOS_W-1:0] r;
      case (k)
         KIND_OR_1: r = SPOS_W'(1);
         KIND_OR_2: r = SPOS_W'(2);
         default:   r = SPOS_W'(3);
      endcase
      seg_len = r;
   endfunction

   function automatic logic far1(input logic signed [SPOS_W-1:0] x,
                                 input logic signed [SPOS_W-1:0] y);
      logic signed [SPOS_W-1:0] d;
      d = x - y;
      far1 = (d > SPOS_W'(1)) || (d < -SPOS_W'(1));
   endfunction

   // a is a swap
   function automatic logic swap_ok(input move_entry_type a, input move_entry_type b);
      logic signed [SPOS_W-1:0] ai, aj, bi, bj, lo, hi, k;
      ai = spos(a.pos_first); aj = spos(a.pos_second);
      bi = spos(b.pos_first); bj = spos(b.pos_second);
      lo = (bi < bj) ? bi : bj;
      hi = (bi < bj) ? bj : bi;
      k  = seg_len(b.kind);
      if (b.kind == KIND_SWAP) begin
         swap_ok = far1(ai, bi) && far1(ai, bj) && far1(aj, bi) && far1(aj, bj);
      end else if (b.kind == KIND_TWO_OPT) begin
         swap_ok = (ai < bi - 1 || ai > bj + 1) && (aj < bi - 1 || aj > bj + 1);
      end else begin
         swap_ok = aj < lo - 1 || ai > hi + k || (ai < lo - 1 && aj > hi + k);
      end
   endfunction

   // a is a two-opt, b is not a swap
   function automatic logic twoopt_ok(input move_entry_type a, input move_entry_type b);
      logic signed [SPOS_W-1:0] ai, aj, bi, bj, lo, hi, k;
      ai = spos(a.pos_first); aj = spos(a.pos_second);
      bi = spos(b.pos_first); bj = spos(b.pos_second);
      lo = (bi < bj) ? bi : bj;
      hi = (bi < bj) ? bj : bi;
      k  = seg_len(b.kind);
      if (b.kind == KIND_TWO_OPT) begin
         twoopt_ok = aj < bi - 1 || ai > bj + 1 || bj < ai - 1 || bi > aj + 1;
      end else begin
         twoopt_ok = ai > hi + k || aj < lo - 1;
      end
   endfunction

   function automatic logic oropt_ok(input move_entry_type a, input move_entry_type b);
      logic signed [SPOS_W-1:0] ai, aj, bi, bj, lo1, hi1, lo2, hi2;
      ai = spos(a.pos_first); aj = spos(a.pos_second);
      bi = spos(b.pos_first); bj = spos(b.pos_second);
      lo1 = (ai < aj) ? ai : aj;
      hi1 = (ai < aj) ? aj : ai;
      lo2 = (bi < bj) ? bi : bj;
      hi2 = (bi < bj) ? bj : bi;
      oropt_ok = hi1 + seg_len(a.kind) < lo2 || lo1 > hi2 + seg_len(b.kind);
   endfunction

   function automatic logic compatible(input move_entry_type a, input move_entry_type b);
      logic r;
      if (a.kind == KIND_SWAP) begin
         r = swap_ok(a, b);
      end else if (a.kind == KIND_TWO_OPT) begin
         r = (b.kind == KIND_SWAP) ? swap_ok(b, a) : twoopt_ok(a, b);
      end else if (b.kind == KIND_SWAP) begin
         r = swap_ok(b, a);
      end else if (b.kind == KIND_TWO_OPT) begin
         r = twoopt_ok(b, a);
      end else begin
         r = oropt_ok(a, b);
      end
      compatible = r;
   endfunction
endpackage

// ===== src/gmms_dpath.sv =====
// Datapath of the selector: move, order and pick memories, counters, output register.
// Depends on gmms_pkg and greedy_move_merge_selector_top_macros.svh.
`timescale 1ns / 1ps
`include "greedy_move_merge_selector_top_macros.svh"
module gmms_dpath import gmms_pkg::*; #(
   parameter int MAX_MOVES = MAX_MOVES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  op_type                op,
   output status_type            status,
   input  logic [MERGE_W-1:0]    max_merge,
   input  logic                  req_tvalid,
   input  logic [55:0]           req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [95:0]           rsp_tdata,
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);
   localparam int IDX_W = $clog2(MAX_MOVES);
   localparam int CNT_W = $clog2(MAX_MOVES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MOVES);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   move_entry_type move_mem [MAX_MOVES];
   logic [IDX_W-1:0] order_mem [MAX_MOVES];
   logic [IDX_W-1:0] pick_mem [RESULT_CAP];

   move_entry_type mv_q_ff, cand_ff, req_move;
   logic [IDX_W-1:0] ord_q_ff, pick_q_ff, cand_idx_ff, cand_idx_in, rank_ff, rank_in;
   logic [IDX_W-1:0] mv_raddr;
   logic mv_rd_en;
   logic [CNT_W-1:0] load_cnt_ff, load_cnt_in, n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0] gain_ff, gain_in;
   logic signed [COST_W-1:0] cost_i_ff, cost_i_in, total_ff, total_in, total_sat;
   logic signed [COST_W:0] total_sum;
   logic [PICK_CNT_W-1:0] npick_ff, npick_in, k_ff, k_in, npick_inc, k_inc;
   logic req_acc, stored, out_load, rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff;
   logic [KIND_W-1:0] rsp_user_ff;
   logic rsp_last_ff;

   assign req_acc  = req_tvalid && (op == OP_LOAD);
   assign stored   = load_cnt_ff < CNT_MAX;
   assign req_move = '{kind: req_tuser, pos_first: req_tdata[9:0],
                       pos_second: req_tdata[19:10], cost: $signed(req_tdata[51:20])};
   assign npick_inc = npick_ff + PICK_CNT_W'(1);
   assign k_inc     = k_ff + PICK_CNT_W'(1);
   assign total_sum = {total_ff[COST_W-1], total_ff} + {mv_q_ff.cost[COST_W-1], mv_q_ff.cost};
   // saturate at the negative limit; the sum of gains never overflows upward
   assign total_sat = (total_sum < -(COST_W+1)'(33'sh080000000)) ?
                      {1'b1, {(COST_W-1){1'b0}}} : total_sum[COST_W-1:0];
   assign out_load = (op == OP_EMIT) && status.out_free;

   always_comb begin
      status.load_last  = req_acc && req_tlast;
      status.j_last     = j_ff == n_ff - CNT_ONE;
      status.i_last     = i_ff == n_ff - CNT_ONE;
      status.gain_lt2   = gain_ff < CNT_W'(2);
      status.npick_zero = npick_ff == '0;
      status.compat_ok  = compatible(mv_q_ff, cand_ff);
      status.k_last     = k_inc == npick_ff;
      status.stop       = (npick_inc == max_merge) || (npick_inc == PICK_CNT_W'(RESULT_CAP));
      status.c_last     = i_ff == gain_ff - CNT_ONE;
      status.out_free   = !rsp_valid_ff || rsp_tready;
      status.out_last   = k_inc == npick_ff;
   end

   always_comb begin
      mv_rd_en = 1'b1;
      case (op)
         OP_RD_I:                mv_raddr = i_ff[IDX_W-1:0];
         OP_RD_J:                mv_raddr = j_ff[IDX_W-1:0];
         OP_RD_CAND:             mv_raddr = ord_q_ff;
         OP_RD_PMV, OP_RD_OMV:   mv_raddr = pick_q_ff;
         default: begin
            mv_raddr = i_ff[IDX_W-1:0];
            mv_rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      load_cnt_in = load_cnt_ff;
      n_in = n_ff; i_in = i_ff; j_in = j_ff; rank_in = rank_ff; gain_in = gain_ff;
      cost_i_in = cost_i_ff; cand_idx_in = cand_idx_ff;
      npick_in = npick_ff; k_in = k_ff; total_in = total_ff;
      case (op)
         OP_LOAD: begin
            if (req_acc) begin
               load_cnt_in = stored ? load_cnt_ff + CNT_ONE : load_cnt_ff;
               if (req_tlast) begin
                  n_in = load_cnt_in;
                  load_cnt_in = '0;
                  i_in = '0;
                  gain_in = '0;
               end
            end
         end
         OP_RD_I: begin
            j_in = '0;
            rank_in = '0;
         end
         OP_LAT_I: begin
            cost_i_in = mv_q_ff.cost;
            if (mv_q_ff.cost < 0) gain_in = gain_ff + CNT_ONE;
         end
         OP_CMP_J: begin
            // stable rank: smaller cost, or equal cost loaded earlier
            if (mv_q_ff.cost < cost_i_ff || (mv_q_ff.cost == cost_i_ff && j_ff < i_ff))
               rank_in = rank_ff + IDX_W'(1);
            j_in = j_ff + CNT_ONE;
         end
         OP_WR_I:      i_in = i_ff + CNT_ONE;
         OP_SEL_START: begin
            i_in = '0;
            npick_in = '0;
         end
         OP_LONE_WR:   npick_in = PICK_CNT_W'(1);
         OP_RD_CAND: begin
            cand_idx_in = ord_q_ff;
            k_in = '0;
         end
         OP_CHK:       k_in = k_inc;
         OP_ACCEPT:    npick_in = npick_inc;
         OP_NEXT_C:    i_in = i_ff + CNT_ONE;
         OP_OUT_START: begin
            k_in = '0;
            total_in = '0;
         end
         OP_EMIT: begin
            if (out_load) begin
               k_in = k_inc;
               total_in = total_sat;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         npick_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         load_cnt_ff <= load_cnt_in;
         npick_ff <= npick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; i_ff <= i_in; j_ff <= j_in; rank_ff <= rank_in; gain_ff <= gain_in;
      cost_i_ff <= cost_i_in; cand_idx_ff <= cand_idx_in; k_ff <= k_in;
      total_ff <= total_in;
      if (op == OP_LAT_CAND) cand_ff <= mv_q_ff;
      if (out_load) begin
         rsp_user_ff <= mv_q_ff.kind;
         rsp_last_ff <= status.out_last;
         rsp_data_ff <= {5'd0,
                         (mv_q_ff.cost < 0) ? k_inc : PICK_CNT_W'(0),
                         total_sat, mv_q_ff.cost, mv_q_ff.pos_second, mv_q_ff.pos_first};
      end
   end

   // memories: one write port each, registered reads
   always_ff @(posedge clock) begin
      if (req_acc && stored) move_mem[load_cnt_ff[IDX_W-1:0]] <= req_move;
      if (mv_rd_en) mv_q_ff <= move_mem[mv_raddr];
   end

   always_ff @(posedge clock) begin
      if (op == OP_WR_I) order_mem[rank_ff] <= i_ff[IDX_W-1:0];
      ord_q_ff <= order_mem[i_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (op == OP_ACCEPT) pick_mem[npick_ff[PICK_IDX_W-1:0]] <= cand_idx_ff;
      else if (op == OP_LONE_WR) pick_mem[0] <= ord_q_ff;
      pick_q_ff <= pick_mem[k_ff[PICK_IDX_W-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `GMMS_ASSERT_NOW(a_npick_cap, npick_ff <= PICK_CNT_W'(RESULT_CAP))
   `GMMS_ASSERT_NOW(a_rank_range, (op != OP_WR_I) || ({1'b0, rank_ff} < {1'b0, n_ff}))
   `GMMS_ASSERT_NEXT(a_emit_shows, out_load, rsp_valid_ff)
endmodule

// ===== src/gmms_ctrl.sv =====
// Controller of the selector: sequences load, rank sort, greedy pick and emit.
// Depends on gmms_pkg.
`timescale 1ns / 1ps
module gmms_ctrl import gmms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output op_type     op,
   output logic       req_ready
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:      if (status.load_last) state_in = ST_RD_I;
         ST_RD_I:      state_in = ST_LAT_I;
         ST_LAT_I:     state_in = ST_RD_J;
         ST_RD_J:      state_in = ST_CMP_J;
         ST_CMP_J:     state_in = status.j_last ? ST_WR_I : ST_RD_J;
         ST_WR_I:      state_in = status.i_last ? ST_SEL_START : ST_RD_I;
         ST_SEL_START: state_in = status.gain_lt2 ? ST_LONE_ORD : ST_RD_ORD;
         ST_LONE_ORD:  state_in = ST_LONE_WR;
         ST_LONE_WR:   state_in = ST_OUT_START;
         ST_RD_ORD:    state_in = ST_RD_CAND;
         ST_RD_CAND:   state_in = ST_LAT_CAND;
         ST_LAT_CAND:  state_in = status.npick_zero ? ST_ACCEPT : ST_RD_PICK;
         ST_RD_PICK:   state_in = ST_RD_PMV;
         ST_RD_PMV:    state_in = ST_CHK;
         ST_CHK: begin
            if (!status.compat_ok) state_in = ST_NEXT_C;
            else if (status.k_last) state_in = ST_ACCEPT;
            else state_in = ST_RD_PICK;
         end
         ST_ACCEPT:    state_in = status.stop ? ST_OUT_START : ST_NEXT_C;
         ST_NEXT_C:    state_in = status.c_last ? ST_OUT_START : ST_RD_ORD;
         ST_OUT_START: state_in = ST_RD_OPK;
         ST_RD_OPK:    state_in = ST_RD_OMV;
         ST_RD_OMV:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) state_in = status.out_last ? ST_LOAD : ST_RD_OPK;
         end
         default:      state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            op = OP_LOAD;
            req_ready = 1'b1;
         end
         ST_RD_I:      op = OP_RD_I;
         ST_LAT_I:     op = OP_LAT_I;
         ST_RD_J:      op = OP_RD_J;
         ST_CMP_J:     op = OP_CMP_J;
         ST_WR_I:      op = OP_WR_I;
         ST_SEL_START: op = OP_SEL_START;
         ST_LONE_ORD:  op = OP_RD_ORD;
         ST_LONE_WR:   op = OP_LONE_WR;
         ST_RD_ORD:    op = OP_RD_ORD;
         ST_RD_CAND:   op = OP_RD_CAND;
         ST_LAT_CAND:  op = OP_LAT_CAND;
         ST_RD_PICK:   op = OP_RD_PICK;
         ST_RD_PMV:    op = OP_RD_PMV;
         ST_CHK:       op = OP_CHK;
         ST_ACCEPT:    op = OP_ACCEPT;
         ST_NEXT_C:    op = OP_NEXT_C;
         ST_OUT_START: op = OP_OUT_START;
         ST_RD_OPK:    op = OP_RD_OPK;
         ST_RD_OMV:    op = OP_RD_OMV;
         ST_EMIT:      op = OP_EMIT;
         default:      op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else state_ff <= state_in;
   end
endmodule

// ===== src/greedy_move_merge_selector_top.sv =====
// Greedy move merge selector: moves stream in on req_, picks stream out on rsp_.
// Load: one move per cycle while the block is in its load phase; req_tlast closes the set.
// After the closing move the block stops taking moves and runs three phases:
//   rank sort: each stored move is ranked against all others through the single
//     read port of the move memory;
//   greedy pick: each gaining move is checked against the earlier picks in turn,
//     up to the first one that conflicts;
//   emit: picks are read back and sent in order, with running saturated total and count.
// If fewer than two moves gain, only the best move is sent, with count 1 or 0.
// rsp_tlast marks the last pick of a run. The result register holds its item while
// rsp_tready is low and the emit phase waits; once the last pick is registered the
// block takes new moves even while that pick still waits to be taken.
// Moves beyond MAX_MOVES are dropped; the run still starts on req_tlast.
// csr_data sets max_merge (0 means no limit); write it only while the block is idle.
// Reset (synchronous, active high) empties the move set, clears max_merge and the
// valid flag of the result register; no clearing pass is needed.
// Depends on gmms_pkg, gmms_ctrl, gmms_dpath.
`timescale 1ns / 1ps
module greedy_move_merge_selector_top import gmms_pkg::*; #(
   parameter int MAX_MOVES = MAX_MOVES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [55:0]        req_tdata,  // pos_first, pos_second, move_cost, zero fill
   input  logic [KIND_W-1:0]  req_tuser,  // move_kind
   input  logic               req_tlast,  // last_move
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [95:0]        rsp_tdata,  // sel_first, sel_second, sel_cost, total_cost,
                                          // picked_count, zero fill
   output logic [KIND_W-1:0]  rsp_tuser,  // sel_kind
   output logic               rsp_tlast,  // final_pick
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [MERGE_W-1:0] csr_data    // max_merge
);
   op_type             op;
   status_type         status;
   logic [MERGE_W-1:0] max_merge_ff, max_merge_in;

   // config register: always ready, hold between writes
   assign csr_ready    = 1'b1;
   assign max_merge_in = csr_valid ? csr_data : max_merge_ff;

   always_ff @(posedge clock) begin
      if (reset) max_merge_ff <= '0;
      else max_merge_ff <= max_merge_in;
   end

   gmms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .op        (op),
      .req_ready (req_tready)
   );

   gmms_dpath #(.MAX_MOVES(MAX_MOVES)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .status     (status),
      .max_merge  (max_merge_ff),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

// ===== bench/greedy_move_merge_selector_top_test.sv =====
// Self-checking bench for the greedy move merge selector: move sets stream in on req_,
// each pick is predicted locally and compared field by field on rsp_.
// Depends on gmms_pkg and greedy_move_merge_selector_top.
`timescale 1ns / 1ps
module greedy_move_merge_selector_top_test;
   import gmms_pkg::*;

   localparam int  STORE_DEPTH = 64;
   localparam int  PICK_CAP    = 64;
   localparam int  CYCLE_LIMIT = 2000000;
   localparam logic [KIND_W-1:0] KIND_OR_3 = 3'd4;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic [POS_W-1:0]         first;
      logic [POS_W-1:0]         second;
      logic signed [COST_W-1:0] cost;
      logic signed [COST_W-1:0] total;
      logic [PICK_CNT_W-1:0]    count;
      logic                     fin;
   } pick_type;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic [POS_W-1:0]         first;
      logic [POS_W-1:0]         second;
      logic signed [COST_W-1:0] cost;
      logic                     last;
      logic                     typed;   // expectation typed in below
      logic signed [COST_W-1:0] etotal;
      logic [PICK_CNT_W-1:0]    ecount;
   } row_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [55:0]         req_tdata;
   logic [KIND_W-1:0]   req_tuser;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [95:0]         rsp_tdata;
   logic [KIND_W-1:0]   rsp_tuser;
   logic                rsp_tlast;
   logic                csr_valid;
   logic                csr_ready;
   logic [MERGE_W-1:0]  csr_data;

   pick_type pending_picks[$];
   int       errors;
   int       cycle_count;
   bit       steady;      // no idling on either side
   bit       hold_req;    // ask the receiver for a long hold-off

   // local copy of the move set and the register
   logic [KIND_W-1:0] mv_kind[STORE_DEPTH];
   int                mv_first[STORE_DEPTH];
   int                mv_second[STORE_DEPTH];
   longint            mv_cost[STORE_DEPTH];
   int                held_moves;
   int                merge_limit;

   greedy_move_merge_selector_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // clock, cycle count and timeout
   initial begin
      clock = 1'b0;
      cycle_count = 0;
      forever begin
         #6 clock = 1'b1;
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
         #6 clock = 1'b0;
      end
   end

   function automatic int seg_size(logic [KIND_W-1:0] k);
      if (k == KIND_OR_1) return 1;
      if (k == KIND_OR_2) return 2;
      return 3;
   endfunction

   function automatic int pos_gap(int x, int y);
      return (x > y) ? x - y : y - x;
   endfunction

   // a is a swap
   function automatic bit swap_fits(int ai, int aj, logic [KIND_W-1:0] kb, int bi, int bj);
      int lo, hi, k;
      lo = (bi < bj) ? bi : bj;
      hi = (bi < bj) ? bj : bi;
      k  = seg_size(kb);
      if (kb == KIND_SWAP)
         return pos_gap(ai, bi) > 1 && pos_gap(ai, bj) > 1 &&
                pos_gap(aj, bi) > 1 && pos_gap(aj, bj) > 1;
      if (kb == KIND_TWO_OPT)
         return (ai < bi - 1 || ai > bj + 1) && (aj < bi - 1 || aj > bj + 1);
      return aj < lo - 1 || ai > hi + k || (ai < lo - 1 && aj > hi + k);
   endfunction

   // a is a two-opt
   function automatic bit twoopt_fits(int ai, int aj, logic [KIND_W-1:0] kb, int bi, int bj);
      int lo, hi;
      lo = (bi < bj) ? bi : bj;
      hi = (bi < bj) ? bj : bi;
      if (kb == KIND_SWAP) return swap_fits(bi, bj, KIND_TWO_OPT, ai, aj);
      if (kb == KIND_TWO_OPT)
         return aj < bi - 1 || ai > bj + 1 || bj < ai - 1 || bi > aj + 1;
      return ai > hi + seg_size(kb) || aj < lo - 1;
   endfunction

   function automatic bit moves_fit(int a, int b);
      int lo1, hi1, lo2, hi2;
      if (mv_kind[a] == KIND_SWAP)
         return swap_fits(mv_first[a], mv_second[a], mv_kind[b], mv_first[b], mv_second[b]);
      if (mv_kind[a] == KIND_TWO_OPT)
         return twoopt_fits(mv_first[a], mv_second[a], mv_kind[b], mv_first[b], mv_second[b]);
      if (mv_kind[b] == KIND_SWAP)
         return swap_fits(mv_first[b], mv_second[b], mv_kind[a], mv_first[a], mv_second[a]);
      if (mv_kind[b] == KIND_TWO_OPT)
         return twoopt_fits(mv_first[b], mv_second[b], mv_kind[a], mv_first[a], mv_second[a]);
      lo1 = (mv_first[a] < mv_second[a]) ? mv_first[a] : mv_second[a];
      hi1 = (mv_first[a] < mv_second[a]) ? mv_second[a] : mv_first[a];
      lo2 = (mv_first[b] < mv_second[b]) ? mv_first[b] : mv_second[b];
      hi2 = (mv_first[b] < mv_second[b]) ? mv_second[b] : mv_first[b];
      return hi1 + seg_size(mv_kind[a]) < lo2 || lo1 > hi2 + seg_size(mv_kind[b]);
   endfunction

   function automatic pick_type make_pick(int m, longint total, int count, bit fin);
      pick_type p;
      p.kind   = mv_kind[m];
      p.first  = mv_first[m][POS_W-1:0];
      p.second = mv_second[m][POS_W-1:0];
      p.cost   = mv_cost[m][COST_W-1:0];
      p.total  = total[COST_W-1:0];
      p.count  = count[PICK_CNT_W-1:0];
      p.fin    = fin;
      return p;
   endfunction

   // Store one accepted move; on the closing move rank, pick and queue the expected picks.
   task automatic merge_move(row_type r, bit queue_picks);
      int     order[STORE_DEPTH];
      bit     blocked[STORE_DEPTH];
      int     n, gains, i, j, count, nres;
      longint total;
      if (held_moves < STORE_DEPTH) begin
         mv_kind[held_moves]   = r.kind;
         mv_first[held_moves]  = int'(r.first);
         mv_second[held_moves] = int'(r.second);
         mv_cost[held_moves]   = longint'(r.cost);
         held_moves++;
      end
      if (!r.last) return;
      n = held_moves;
      held_moves = 0;
      // stable insertion sort, ties kept in load order
      for (i = 0; i < n; i++) begin
         j = i;
         while (j > 0 && mv_cost[order[j-1]] > mv_cost[i]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = i;
      end
      gains = 0;
      while (gains < n && mv_cost[order[gains]] < 0) gains++;
      if (!queue_picks) return;
      if (gains < 2) begin
         pending_picks.push_back(make_pick(order[0], mv_cost[order[0]],
                                           (mv_cost[order[0]] < 0) ? 1 : 0, 1'b1));
         return;
      end
      for (i = 0; i < STORE_DEPTH; i++) blocked[i] = 1'b0;
      count = 0;
      nres  = 0;
      total = 0;
      for (i = 0; i < gains; i++) begin
         if (blocked[i]) continue;
         total += mv_cost[order[i]];
         if (total < -64'sd2147483648) total = -64'sd2147483648;
         count++;
         pending_picks.push_back(make_pick(order[i], total, count, 1'b0));
         nres++;
         if (count == merge_limit || nres == PICK_CAP) break;
         blocked[i] = 1'b1;
         for (j = i + 1; j < gains; j++)
            if (!moves_fit(order[i], order[j])) blocked[j] = 1'b1;
      end
      pending_picks[pending_picks.size()-1].fin = 1'b1;
   endtask

   // Offer one move, hold it until accepted, then update the expectations.
   // Return at the next falling edge with the item still on the bus; the next
   // call replaces it, and stop_sending drops it when no move follows.
   task automatic send_move(row_type r);
      if (!steady && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tlast  <= r.last;
      req_tdata  <= {4'b0, r.cost, r.second, r.first};
      do @(posedge clock); while (!req_tready);
      if (r.typed) begin
         merge_move(r, 1'b0);
         pending_picks.push_back('{r.kind, r.first, r.second, r.cost,
                                   r.etotal, r.ecount, 1'b1});
      end else begin
         merge_move(r, 1'b1);
      end
      @(negedge clock);
   endtask

   // Drop the input valid once no move follows; call at a falling edge.
   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   // Wait until the block is idle, then write max_merge.
   task automatic write_merge_limit(int value);
      stop_sending();
      wait (pending_picks.size() == 0);
      repeat (50) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value[MERGE_W-1:0];
      do @(posedge clock); while (!csr_ready);
      merge_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic row_type plain_row(logic [KIND_W-1:0] k, int a, int b,
                                         longint c, bit last);
      row_type r;
      r.kind = k; r.first = a[POS_W-1:0]; r.second = b[POS_W-1:0];
      r.cost = c[COST_W-1:0]; r.last = last; r.typed = 1'b0;
      r.etotal = '0; r.ecount = '0;
      return r;
   endfunction

   function automatic row_type lone_row(logic [KIND_W-1:0] k, int a, int b,
                                        longint c, int cnt);
      row_type r;
      r = plain_row(k, a, b, c, 1'b1);
      r.typed = 1'b1; r.etotal = c[COST_W-1:0]; r.ecount = cnt[PICK_CNT_W-1:0];
      return r;
   endfunction

   // Random move; narrow positions crowd moves together so conflicts happen.
   function automatic row_type random_row(bit last);
      row_type r;
      int      span;
      longint  c;
      span = ($urandom_range(3) == 0) ? 1023 : 60;
      case ($urandom_range(9))
         0:       c = longint'($signed($urandom()));
         1:       c = -64'sd2147483648 + $urandom_range(3);
         2:       c = $urandom_range(500);
         default: c = -longint'($urandom_range(1000));
      endcase
      r = plain_row(($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4)),
                    $urandom_range(span), $urandom_range(span), c, last);
      return r;
   endfunction

   task automatic send_random_set(int size);
      for (int i = 0; i < size; i++) send_move(random_row(i == size - 1));
   endtask

   row_type directed[$];

   // sender and phase control
   initial begin
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0; req_tlast = 1'b0;
      csr_valid = 1'b0; csr_data = '0;
      reset = 1'b1;
      errors = 0; steady = 1'b0; hold_req = 1'b0;
      held_moves = 0; merge_limit = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lone moves: extremes of every field, zero and cost limits
      directed.push_back(lone_row(KIND_SWAP, 5, 9, 7, 0));
      directed.push_back(lone_row(KIND_OR_3, 1023, 0, -64'sd2147483648, 1));
      directed.push_back(lone_row(3'd7, 0, 1023, 64'sd2147483647, 0));
      directed.push_back(lone_row(KIND_TWO_OPT, 512, 511, 0, 0));
      // tied gains, kept in load order
      directed.push_back(plain_row(KIND_SWAP, 10, 20, -5, 0));
      directed.push_back(plain_row(KIND_SWAP, 100, 200, -5, 1));
      // two minimum costs saturate the total
      directed.push_back(plain_row(KIND_SWAP, 0, 1023, -64'sd2147483648, 0));
      directed.push_back(plain_row(KIND_SWAP, 500, 600, -64'sd2147483648, 1));
      // a single gain among two moves
      directed.push_back(plain_row(KIND_TWO_OPT, 3, 8, 5, 0));
      directed.push_back(plain_row(KIND_OR_1, 30, 40, -1, 1));
      // overlapping mix of every kind
      directed.push_back(plain_row(KIND_TWO_OPT, 10, 20, -3, 0));
      directed.push_back(plain_row(KIND_OR_1, 15, 16, -4, 0));
      directed.push_back(plain_row(KIND_OR_2, 50, 52, -2, 0));
      directed.push_back(plain_row(KIND_SWAP, 21, 30, -1, 0));
      directed.push_back(plain_row(KIND_OR_3, 60, 61, -6, 0));
      directed.push_back(plain_row(3'd6, 63, 70, -7, 1));
      // zero cost does not gain
      directed.push_back(plain_row(KIND_SWAP, 5, 6, 0, 0));
      directed.push_back(plain_row(KIND_SWAP, 8, 9, -1, 1));

      write_merge_limit(0);
      foreach (directed[i]) send_move(directed[i]);

      // full store: 64 spaced gains reach the pick cap, the extra moves are dropped
      steady = 1'b1;
      for (int i = 0; i < 66; i++)
         send_move(plain_row(KIND_OR_3, i * 15, i * 15 + 1, -longint'(i + 1), i == 65));
      steady = 1'b0;

      write_merge_limit(1);
      repeat (2) send_random_set($urandom_range(2, 6));

      // long receiver hold-off while moves keep coming
      write_merge_limit(127);
      hold_req = 1'b1;
      repeat (2) send_random_set($urandom_range(2, 8));

      write_merge_limit(64);
      repeat (2) send_random_set($urandom_range(1, 8));

      write_merge_limit(3);
      repeat (2) send_random_set($urandom_range(3, 8));

      write_merge_limit($urandom_range(2, 6));
      repeat (2) send_random_set($urandom_range(1, 8));

      write_merge_limit(0);
      repeat (2) send_random_set($urandom_range(2, 6));

      stop_sending();
      wait (pending_picks.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // receiver: random stalls, a calm stretch, and one long hold-off on request
   initial begin
      int hold_left;
      rsp_tready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 13);
         end
      end
   end

   // compare every accepted pick with the oldest expectation
   always @(posedge clock) begin
      pick_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_picks.size() == 0) begin
            $error("unexpected pick: kind %0d first %0d", rsp_tuser, rsp_tdata[9:0]);
            errors++;
         end else begin
            want = pending_picks.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("sel_kind expected %0d actual %0d", want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[9:0] !== want.first) begin
               $error("sel_first expected %0d actual %0d", want.first, rsp_tdata[9:0]);
               errors++;
            end
            if (rsp_tdata[19:10] !== want.second) begin
               $error("sel_second expected %0d actual %0d", want.second, rsp_tdata[19:10]);
               errors++;
            end
            if (rsp_tdata[51:20] !== want.cost) begin
               $error("sel_cost expected %0d actual %0d", want.cost,
                      $signed(rsp_tdata[51:20]));
               errors++;
            end
            if (rsp_tdata[83:52] !== want.total) begin
               $error("total_cost expected %0d actual %0d", want.total,
                      $signed(rsp_tdata[83:52]));
               errors++;
            end
            if (rsp_tdata[90:84] !== want.count) begin
               $error("picked_count expected %0d actual %0d", want.count, rsp_tdata[90:84]);
               errors++;
            end
            if (rsp_tlast !== want.fin) begin
               $error("final_pick expected %0d actual %0d", want.fin, rsp_tlast);
               errors++;
            end
         end
      end
   end
endmodule
